@@ hw/rtl/kbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types and constants of the keyed balance table.
// ----------------------------------------------------------------------------
package kbt_pkg;

   localparam int KEY_W = 32;
   localparam int AMT_W = 62;
   localparam int BAL_W = 63;
   localparam int OUT_W = 64;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_DEBIT  = 2'd1,
      CMD_CREDIT = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   // one queued command between front and back
   typedef struct packed {
      cmd_type            cmd;
      logic [KEY_W-1:0]   key;
      logic [AMT_W-1:0]   amt;
   } item_type;

   // queue status seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

@@ hw/rtl/kbt_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_req_if
// Command channel: valid/ready with command, key and amount.
// ----------------------------------------------------------------------------
interface kbt_req_if;
   import kbt_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] key;
   logic [61:0]        amount;

   modport source (output valid, output command, output key, output amount, input ready);
   modport sink   (input valid, input command, input key, input amount, output ready);
endinterface

@@ hw/rtl/kbt_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_rsp_if
// Result channel: valid/ready with success, balance and table_full.
// ----------------------------------------------------------------------------
interface kbt_rsp_if;
   import kbt_pkg::*;

   logic               valid;
   logic               ready;
   logic               success;
   logic signed [63:0] balance;
   logic               table_full;

   modport source (output valid, output success, output balance, output table_full,
                   input ready);
   modport sink   (input valid, input success, input balance, input table_full,
                   output ready);
endinterface

@@ hw/rtl/kbt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module kbt_front (
   input  logic                    clock,
   input  logic                    reset,
   kbt_req_if.sink                 req_chan,
   input  logic                    pop,
   output kbt_pkg::queue_head_type head
);
   import kbt_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       do_pop;
   item_type   new_item;

   // decode the incoming transfer
   always_comb begin
      new_item.cmd = cmd_type'(req_chan.command);
      new_item.key = req_chan.key;
      new_item.amt = req_chan.amount;
   end

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (cnt_ff != 2'd0);

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ hw/rtl/kbt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_back
// Searches the key memory, then updates the balance memory and posts the result.
// ----------------------------------------------------------------------------
module kbt_back #(
   parameter int ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kbt_pkg::queue_head_type head,
   output logic                   pop,
   kbt_rsp_if.source              rsp_chan
);
   import kbt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY_RD,
      ST_KEY_CMP,
      ST_EXEC
   } state_type;

   state_type        state_ff;
   item_type         item_ff;
   logic [IW-1:0]    idx_ff;
   logic [CW-1:0]    count_ff;
   logic             found_ff;
   logic             rsp_valid_ff;
   logic             rsp_success_ff;
   logic [OUT_W-1:0] rsp_balance_ff;
   logic             rsp_full_ff;

   logic [KEY_W-1:0] key_mem [ENTRIES];
   logic [BAL_W-1:0] bal_mem [ENTRIES];
   logic [KEY_W-1:0] key_rd_ff;
   logic [BAL_W-1:0] bal_rd_ff;

   logic             has_room;
   logic [OUT_W-1:0] sum;
   logic [BAL_W-1:0] sat_sum;
   logic             can_debit;
   logic [BAL_W-1:0] diff;
   logic             key_we;
   logic             bal_we;
   logic [BAL_W-1:0] bal_wr;
   logic [IW-1:0]    wr_idx;
   logic             ex_success;
   logic [OUT_W-1:0] ex_balance;
   logic             ex_full;
   logic [CW-1:0]    idx_next;
   logic             exec_go;

   assign pop      = (state_ff == ST_IDLE) && head.valid;
   assign has_room = (count_ff < CW'(ENTRIES));
   assign idx_next = CW'(idx_ff) + CW'(1);
   // execute once the output register is free or being emptied
   assign exec_go  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   // saturating add and debit check on the stored balance
   always_comb begin
      sum       = {1'b0, bal_rd_ff} + {2'b00, item_ff.amt};
      sat_sum   = sum[OUT_W-1] ? {BAL_W{1'b1}} : sum[BAL_W-1:0];
      can_debit = (bal_rd_ff >= {1'b0, item_ff.amt});
      diff      = bal_rd_ff - {1'b0, item_ff.amt};
   end

   // command execution
   always_comb begin
      key_we     = 1'b0;
      bal_we     = 1'b0;
      bal_wr     = sat_sum;
      wr_idx     = found_ff ? idx_ff : count_ff[IW-1:0];
      ex_success = 1'b0;
      ex_balance = {OUT_W{1'b1}};
      ex_full    = 1'b0;
      case (item_ff.cmd)
         CMD_CREATE: begin
            if (found_ff) begin
               bal_we     = 1'b1;
               ex_balance = {1'b0, sat_sum};
            end else if (has_room) begin
               key_we     = 1'b1;
               bal_we     = 1'b1;
               bal_wr     = {1'b0, item_ff.amt};
               ex_success = 1'b1;
               ex_balance = {2'b00, item_ff.amt};
            end else begin
               ex_full = 1'b1;
            end
         end
         CMD_DEBIT: begin
            if (found_ff) begin
               if (can_debit) begin
                  bal_we     = 1'b1;
                  bal_wr     = diff;
                  ex_success = 1'b1;
                  ex_balance = {1'b0, diff};
               end else begin
                  ex_balance = {1'b0, bal_rd_ff};
               end
            end
         end
         CMD_CREDIT: begin
            if (found_ff) begin
               bal_we     = 1'b1;
               ex_success = 1'b1;
               ex_balance = {1'b0, sat_sum};
            end
         end
         default: begin
            if (found_ff) begin
               ex_success = 1'b1;
               ex_balance = {1'b0, bal_rd_ff};
            end
         end
      endcase
      if (!exec_go) begin
         key_we = 1'b0;
         bal_we = 1'b0;
      end
   end

   // key and balance memories, registered reads
   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[idx_ff];
      bal_rd_ff <= bal_mem[idx_ff];
      if (key_we) begin
         key_mem[wr_idx] <= item_ff.key;
      end
      if (bal_we) begin
         bal_mem[wr_idx] <= bal_wr;
      end
   end

   // sequencer: probe one key at a time, read then compare, then execute
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         if (exec_go) begin
            rsp_valid_ff   <= 1'b1;
            rsp_success_ff <= ex_success;
            rsp_balance_ff <= ex_balance;
            rsp_full_ff    <= ex_full;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  item_ff  <= head.item;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= (count_ff == '0) ? ST_EXEC : ST_KEY_RD;
               end
            end
            ST_KEY_RD: begin
               state_ff <= ST_KEY_CMP;
            end
            ST_KEY_CMP: begin
               if (key_rd_ff == item_ff.key) begin
                  found_ff <= 1'b1;
                  state_ff <= ST_EXEC;
               end else if (idx_next == count_ff) begin
                  state_ff <= ST_EXEC;
               end else begin
                  idx_ff   <= idx_next[IW-1:0];
                  state_ff <= ST_KEY_RD;
               end
            end
            ST_EXEC: begin
               if (exec_go) begin
                  if (key_we) begin
                     count_ff <= count_ff + CW'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.success    = rsp_success_ff;
   assign rsp_chan.balance    = rsp_balance_ff;
   assign rsp_chan.table_full = rsp_full_ff;

`ifndef SYNTHESIS
   // fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count beyond table size");

   // a refused create never reports success
   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_full_ff |-> !rsp_success_ff)
      else $error("table_full together with success");

   // new entry allocation bumps the count by one
   a_alloc: assert property (@(posedge clock) disable iff (reset)
      key_we |=> count_ff == $past(count_ff) + CW'(1))
      else $error("allocation did not advance entry count");

   // a waiting result stays in place until its transfer
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_balance_ff))
      else $error("result overwrite");
`endif

endmodule

@@ hw/rtl/keyed_balance_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_balance_table_top
// Keyed table of saturating balances with create, debit, credit and query.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and are carried out one at a time. The
// key memory has a single read port and is probed in allocation order, one
// stored entry at a time with a read and then a compare, until the key is
// found or all n entries in use have been probed; on an empty table the
// probe is skipped. Results wait in an output register while the queue keeps
// taking commands until it is full. No clearing pass is needed after reset.
module keyed_balance_table_top #(
   parameter int ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   kbt_req_if.sink    req_chan,
   kbt_rsp_if.source  rsp_chan
);
   import kbt_pkg::*;

   queue_head_type head;
   logic           pop;

   kbt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   kbt_back #(.ENTRIES(ENTRIES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ tb/sv/tb_kbt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kbt_checker
// Watches the command and result channels of the keyed balance table, keeps
// its own copy of the key and balance stores, and compares every result.
// ----------------------------------------------------------------------------
module tb_kbt_checker #(
   parameter int ENTRIES = 256
) (
   input  logic clock,
   input  logic reset,
   kbt_req_if.sink   req_mon,
   kbt_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count,
   output int        entries_used
);
   import kbt_pkg::*;

   typedef struct {
      logic        success;
      logic [63:0] balance;
      logic        table_full;
   } outcome_type;

   localparam logic [63:0] BAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ABSENT  = '1;

   logic [KEY_W-1:0] key_copy [ENTRIES];
   logic [63:0]      bal_copy [ENTRIES];
   int               used;
   outcome_type      expected_q [$];

   assign pending_count = expected_q.size();
   assign entries_used  = used;

   // saturating add of two values below 2^63
   function automatic logic [63:0] add_capped(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > BAL_MAX) ? BAL_MAX : s;
   endfunction

   // apply one command to the shadow table and return its outcome
   function automatic outcome_type apply_command(cmd_type cmd, logic [KEY_W-1:0] key,
                                                 logic [AMT_W-1:0] amt);
      outcome_type o;
      int          idx;
      logic [63:0] a;
      idx = -1;
      a = {2'b00, amt};
      o.success = 1'b0;
      o.balance = ABSENT;
      o.table_full = 1'b0;
      for (int i = 0; i < used; i++)
         if (idx < 0 && key_copy[i] == key) idx = i;
      case (cmd)
         CMD_CREATE: begin
            if (idx >= 0) begin
               bal_copy[idx] = add_capped(bal_copy[idx], a);
               o.balance = bal_copy[idx];
            end else if (used < ENTRIES) begin
               key_copy[used] = key;
               bal_copy[used] = a;
               used++;
               o.success = 1'b1;
               o.balance = a;
            end else begin
               o.table_full = 1'b1;
            end
         end
         CMD_DEBIT: begin
            if (idx >= 0) begin
               if (bal_copy[idx] >= a) begin
                  bal_copy[idx] = bal_copy[idx] - a;
                  o.success = 1'b1;
               end
               o.balance = bal_copy[idx];
            end
         end
         CMD_CREDIT: begin
            if (idx >= 0) begin
               bal_copy[idx] = add_capped(bal_copy[idx], a);
               o.success = 1'b1;
               o.balance = bal_copy[idx];
            end
         end
         default: begin
            if (idx >= 0) begin
               o.success = 1'b1;
               o.balance = bal_copy[idx];
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   // predict on each command transfer, compare on each result transfer
   always @(posedge clock) begin
      outcome_type w;
      if (reset) begin
         used = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_mon.balance, '0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_mon.success !== w.success)
                  report_mismatch("success", {63'd0, rsp_mon.success},
                                  {63'd0, w.success});
               if (rsp_mon.balance !== w.balance)
                  report_mismatch("balance", rsp_mon.balance, w.balance);
               if (rsp_mon.table_full !== w.table_full)
                  report_mismatch("table_full", {63'd0, rsp_mon.table_full},
                                  {63'd0, w.table_full});
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(apply_command(cmd_type'(req_mon.command),
                                               req_mon.key, req_mon.amount));
      end
   end
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyed balance table: directed corner commands,
// then random traffic, mostly over a small key pool, with fresh keys that fill the table.
// ----------------------------------------------------------------------------
module tb_top;
   import kbt_pkg::*;

   localparam int  ENTRIES   = 256;
   localparam int  N_RANDOM  = 1030;
   localparam longint LIMIT  = 3_000_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   entries_used;
   longint cycle_count = 0;
   int   burst_left;
   int   stall_phase;
   logic [KEY_W-1:0] key_pool [64];

   kbt_req_if req_chan ();
   kbt_rsp_if rsp_chan ();

   keyed_balance_table_top #(.ENTRIES(ENTRIES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   tb_kbt_checker #(.ENTRIES(ENTRIES)) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .entries_used  (entries_used)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // timeout counter
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stalls on its own pattern, with long stretches of no stall
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset)
         rsp_chan.ready <= 1'b0;
      else if ((stall_phase / 300) % 3 == 0)
         rsp_chan.ready <= 1'b1;
      else if ((stall_phase / 300) % 3 == 1)
         rsp_chan.ready <= (stall_phase % 7) < 4;
      else
         rsp_chan.ready <= ($urandom_range(0, 9) < 3);
   end

   // send one command, holding valid until transfer; gaps come between bursts
   task automatic send_command(cmd_type cmd, logic [KEY_W-1:0] key, logic [AMT_W-1:0] amt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.key     <= key;
      req_chan.amount  <= amt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [AMT_W-1:0] random_amount();
      logic [AMT_W-1:0] a;
      a = AMT_W'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: a = a & 62'hFF;
         1: a = a & 62'hFFFF_FFFF;
         default: ;
      endcase
      return a;
   endfunction

   initial begin
      cmd_type          c;
      logic [KEY_W-1:0] k;
      burst_left = 0;
      stall_phase = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_CREATE;
      req_chan.key = '0;
      req_chan.amount = '0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: absent keys on an empty table
      send_command(CMD_QUERY, 32'h0, '0);
      send_command(CMD_DEBIT, 32'h8000_0000, 62'd5);
      send_command(CMD_CREDIT, 32'h7FFF_FFFF, 62'd5);
      // extreme keys and amounts, saturation
      send_command(CMD_CREATE, 32'h8000_0000, '1);
      send_command(CMD_CREATE, 32'h7FFF_FFFF, '0);
      send_command(CMD_CREATE, 32'hFFFF_FFFF, 62'd100);
      send_command(CMD_CREATE, 32'h8000_0000, '1);
      send_command(CMD_CREATE, 32'h8000_0000, '1);
      send_command(CMD_CREDIT, 32'h8000_0000, '1);
      send_command(CMD_QUERY, 32'h8000_0000, '1);
      // debit too large, exact, then zero
      send_command(CMD_DEBIT, 32'hFFFF_FFFF, 62'd101);
      send_command(CMD_DEBIT, 32'hFFFF_FFFF, 62'd100);
      send_command(CMD_DEBIT, 32'hFFFF_FFFF, 62'd0);
      send_command(CMD_CREDIT, 32'h7FFF_FFFF, 62'h2AAA_AAAA_AAAA_AAAA);
      send_command(CMD_DEBIT, 32'h7FFF_FFFF, 62'h1555_5555_5555_5555);
      send_command(CMD_QUERY, 32'h7FFF_FFFF, '0);
      wait_drained();

      // random: small key pool so most commands hit, table fills midway
      for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) wait_drained();
         c = cmd_type'($urandom_range(0, 3));
         if (n > 300 && n < 700 && $urandom_range(0, 1) == 0) begin
            // fresh keys to fill the table and hit the full case
            c = CMD_CREATE;
            k = $urandom;
         end else if ($urandom_range(0, 9) < 8) begin
            k = key_pool[$urandom_range(0, 63)];
         end else begin
            k = $urandom;
         end
         send_command(c, k, random_amount());
      end

      wait_drained();
      repeat (2 * ENTRIES + 50) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

@@ keyed_balance_table_top.f @@
hw/rtl/kbt_pkg.sv
hw/rtl/kbt_req_if.sv
hw/rtl/kbt_rsp_if.sv
hw/rtl/kbt_front.sv
hw/rtl/kbt_back.sv
hw/rtl/keyed_balance_table_top.sv
tb/sv/tb_kbt_checker.sv
tb/sv/tb_top.sv
